### hw/rtl/shlp_pkg.sv
// Types, codes and per-byte parse functions for the stream header line parser.
// No dependencies.
package shlp_pkg;

   typedef enum logic [2:0] {
      ERR_OK          = 3'd0,
      ERR_IO          = 3'd1,
      ERR_INVALID     = 3'd2,
      ERR_TOO_LONG    = 3'd3,
      ERR_UNSUPPORTED = 3'd4,
      ERR_UNKNOWN_TOK = 3'd5
   } err_type;

   typedef enum logic [1:0] {
      PH_IDENT = 2'd0,
      PH_LEN   = 2'd1,
      PH_TOKEN = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      INTEG_NONE  = 2'd0,
      INTEG_CRC   = 2'd1,
      INTEG_SIG   = 2'd2
   } integ_type;

   localparam int KF_VALID = 0;
   localparam int KF_CRC   = 1;
   localparam int KF_SIG   = 2;
   localparam int KF_COLON = 3;
   localparam int VF_UPPER = 0;
   localparam int VF_LOWER = 1;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_DASH  = 8'h2D;

   localparam logic [4:0] POS_MAX = 5'd31;
   localparam logic [4:0] CRC_DIGITS = 5'd8;
   localparam logic [4:0] SIG_DIGITS = 5'd16;

   localparam int ID_LEN0 = 4;
   localparam int ID_LEN1 = 20;
   localparam int ID_LEN2 = 23;
   localparam int ID_LEN3 = 4;
   localparam logic [8*ID_LEN0-1:0] ID_TEXT0 = {"OS", "F4"};
   localparam logic [8*ID_LEN1-1:0] ID_TEXT1 = {"OCEAN_STREAM", "_FORMAT4"};
   localparam logic [8*ID_LEN2-1:0] ID_TEXT2 = {"OCEAN_STREAM", "ING", "_FORMAT4"};
   localparam logic [8*ID_LEN3-1:0] ID_TEXT3 = {"OS", "F5"};

   localparam int KEY_CRC_LEN = 6;
   localparam int KEY_SIG_LEN = 7;
   localparam logic [8*KEY_CRC_LEN-1:0] KEY_CRC = "crc32c";
   localparam logic [8*KEY_SIG_LEN-1:0] KEY_SIG = "ed25519";

   typedef struct packed {
      logic [7:0] line_byte;
      logic       end_of_input;
      logic       stream_fault;
   } req_type;

   typedef struct packed {
      err_type     error_code;
      logic        format_version;
      logic [63:0] block_length;
      logic [1:0]  integrity_kind;
      logic        crc_present;
      logic [31:0] crc_value;
   } rsp_type;

   typedef struct packed {
      phase_type   phase;
      logic        held_cr;
      logic [3:0]  cand;
      err_type     first_error;
      logic        version;
      logic [63:0] acc;
      logic        digit_seen;
      logic [4:0]  tpos;
      logic [3:0]  kflags;
      logic [1:0]  vflags;
      logic [31:0] vshift;
      logic [4:0]  vcount;
      logic [31:0] crc;
      logic [1:0]  integ;
      logic        crc_seen;
   } state_type;

   function automatic state_type idle_state();
      state_type s;
      s = '0;
      s.phase = PH_IDENT;
      s.cand = 4'hF;
      s.first_error = ERR_OK;
      s.kflags = 4'b0111;
      return s;
   endfunction

   function automatic state_type latch_err(state_type s, err_type code);
      state_type r;
      r = s;
      if (r.first_error == ERR_OK) begin
         r.first_error = code;
      end
      return r;
   endfunction

   function automatic state_type start_token(state_type s);
      state_type r;
      r = s;
      r.tpos = '0;
      r.kflags = 4'b0111;
      r.vflags = '0;
      r.vshift = '0;
      r.vcount = '0;
      return r;
   endfunction

   function automatic state_type finish_token(state_type s);
      state_type r;
      r = s;
      if (s.tpos == 5'd0 || !s.kflags[KF_VALID]) begin
         r = latch_err(r, ERR_INVALID);
      end else if (s.kflags[KF_CRC] && s.tpos == 5'(KEY_CRC_LEN)) begin
         if (s.vcount == CRC_DIGITS && s.vflags[VF_UPPER]) begin
            r.crc = s.vshift;
            r.crc_seen = 1'b1;
            r.integ = INTEG_CRC;
         end else begin
            r = latch_err(r, ERR_INVALID);
         end
      end else if (s.kflags[KF_SIG] && s.tpos == 5'(KEY_SIG_LEN)) begin
         if (s.vcount != SIG_DIGITS || !s.vflags[VF_LOWER] || !s.crc_seen) begin
            r = latch_err(r, ERR_INVALID);
         end else begin
            r.integ = INTEG_SIG;
         end
      end else begin
         r = latch_err(r, ERR_UNKNOWN_TOK);
      end
      return r;
   endfunction

   function automatic logic id_char_ok(int k, logic [4:0] pos, logic [7:0] c);
      int p;
      logic ok;
      p = int'(pos);
      ok = 1'b0;
      case (k)
         0: ok = (p < ID_LEN0) && (ID_TEXT0[8*(ID_LEN0-1-p) +: 8] == c);
         1: ok = (p < ID_LEN1) && (ID_TEXT1[8*(ID_LEN1-1-p) +: 8] == c);
         2: ok = (p < ID_LEN2) && (ID_TEXT2[8*(ID_LEN2-1-p) +: 8] == c);
         default: ok = (p < ID_LEN3) && (ID_TEXT3[8*(ID_LEN3-1-p) +: 8] == c);
      endcase
      return ok;
   endfunction

   function automatic state_type feed(state_type s, logic [7:0] c);
      state_type r;
      logic dig, up, lo;
      logic [3:0] ok, d;
      logic [67:0] prod;
      r = s;
      dig = (c >= "0") && (c <= "9");
      up = (c >= "A") && (c <= "F");
      lo = (c >= "a") && (c <= "f");
      d = dig ? 4'(c - "0") : (up ? 4'(c - "A" + 8'd10) : (lo ? 4'(c - "a" + 8'd10) : 4'd0));
      prod = ({4'd0, s.acc} << 3) + ({4'd0, s.acc} << 1) + {64'd0, d};
      case (s.phase)
         PH_IDENT: begin
            if (c == CH_SPACE) begin
               ok[0] = s.cand[0] && (s.tpos == 5'(ID_LEN0));
               ok[1] = s.cand[1] && (s.tpos == 5'(ID_LEN1));
               ok[2] = s.cand[2] && (s.tpos == 5'(ID_LEN2));
               ok[3] = s.cand[3] && (s.tpos == 5'(ID_LEN3));
               if (ok == 4'd0) begin
                  r = latch_err(r, ERR_UNSUPPORTED);
               end
               r.version = ok[3];
               r.phase = PH_LEN;
               r.tpos = '0;
            end else begin
               for (int k = 0; k < 4; k++) begin
                  if (!id_char_ok(k, s.tpos, c)) begin
                     r.cand[k] = 1'b0;
                  end
               end
               if (s.tpos < POS_MAX) begin
                  r.tpos = s.tpos + 5'd1;
               end
            end
         end
         PH_LEN: begin
            if (c == CH_SPACE) begin
               if (!s.digit_seen || !s.version) begin
                  r = latch_err(r, ERR_INVALID);
               end
               r.phase = PH_TOKEN;
               r = start_token(r);
            end else if (dig) begin
               if (prod[67:64] != 4'd0) begin
                  r = latch_err(r, ERR_INVALID);
               end
               r.acc = prod[63:0];
               r.digit_seen = 1'b1;
            end else begin
               r = latch_err(r, ERR_INVALID);
            end
         end
         default: begin
            if (c == CH_SPACE) begin
               r = finish_token(r);
               r = start_token(r);
            end else if (!s.kflags[KF_COLON]) begin
               if (c == CH_COLON) begin
                  r.kflags[KF_COLON] = 1'b1;
                  r.vflags = 2'b11;
                  r.vshift = '0;
                  r.vcount = '0;
               end else begin
                  if (!((c >= "a" && c <= "z") || dig || c == CH_DASH)) begin
                     r.kflags[KF_VALID] = 1'b0;
                  end
                  if (!(int'(s.tpos) < KEY_CRC_LEN &&
                        KEY_CRC[8*(KEY_CRC_LEN-1-int'(s.tpos)) +: 8] == c)) begin
                     r.kflags[KF_CRC] = 1'b0;
                  end
                  if (!(int'(s.tpos) < KEY_SIG_LEN &&
                        KEY_SIG[8*(KEY_SIG_LEN-1-int'(s.tpos)) +: 8] == c)) begin
                     r.kflags[KF_SIG] = 1'b0;
                  end
                  if (s.tpos < POS_MAX) begin
                     r.tpos = s.tpos + 5'd1;
                  end
               end
            end else begin
               if (!dig && !up) begin
                  r.vflags[VF_UPPER] = 1'b0;
               end
               if (!dig && !lo) begin
                  r.vflags[VF_LOWER] = 1'b0;
               end
               r.vshift = {s.vshift[27:0], d};
               if (s.vcount < POS_MAX) begin
                  r.vcount = s.vcount + 5'd1;
               end
            end
         end
      endcase
      return r;
   endfunction

endpackage

### hw/rtl/stream_header_line_parser.sv
// Stream header line parser top level: state register, per-byte update, result register.
// Depends on shlp_pkg.
// The result is registered: it appears in the cycle after the byte that completes the line.
// Throughput: one byte per cycle while ready is high; the per-byte update is one pass of logic.
// Ready stays high while the result register is empty or being drained.
// Reset puts the parser in the identifier phase and empties the result register.
module stream_header_line_parser
   import shlp_pkg::*;
#(
   parameter int MAX_LINE_LEN = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int LcW = $clog2(MAX_LINE_LEN + 1);

   state_type      state_ff, state_in, st;
   logic [LcW-1:0] line_count_ff, line_count_in;
   rsp_type        rsp_ff, rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           accept, emit;
   err_type        code;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      st = state_ff;
      emit = 1'b0;
      code = ERR_OK;
      line_count_in = line_count_ff;
      if (req_data.stream_fault) begin
         emit = 1'b1;
         code = ERR_IO;
      end else if (req_data.end_of_input) begin
         emit = 1'b1;
         code = ERR_INVALID;
      end else if (req_data.line_byte == CH_LF) begin
         st.held_cr = 1'b0;
         case (state_ff.phase)
            PH_IDENT: st = latch_err(st, ERR_INVALID);
            PH_LEN: begin
               if (!state_ff.digit_seen) begin
                  st = latch_err(st, ERR_INVALID);
               end
            end
            default: st = finish_token(st);
         endcase
         emit = 1'b1;
         code = st.first_error;
      end else if (line_count_ff == LcW'(MAX_LINE_LEN)) begin
         emit = 1'b1;
         code = ERR_TOO_LONG;
      end else begin
         line_count_in = line_count_ff + LcW'(1);
         if (state_ff.held_cr) begin
            st.held_cr = 1'b0;
            st = feed(st, CH_CR);
         end
         if (req_data.line_byte == CH_CR) begin
            st.held_cr = 1'b1;
         end else begin
            st = feed(st, req_data.line_byte);
         end
      end

      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      state_in = state_ff;
      if (accept) begin
         if (emit) begin
            state_in = idle_state();
            line_count_in = '0;
            rsp_valid_in = 1'b1;
            rsp_in = '0;
            rsp_in.error_code = code;
            if (code == ERR_OK) begin
               rsp_in.format_version = st.version;
               rsp_in.block_length = st.acc;
               rsp_in.integrity_kind = st.integ;
               rsp_in.crc_present = st.crc_seen;
               rsp_in.crc_value = st.crc;
            end
         end else begin
            state_in = st;
         end
      end else begin
         line_count_in = line_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= idle_state();
         line_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         line_count_ff <= line_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule
